>>> rtl/core/kdq_pkg.sv
// Shared key codes, entry state type and scaling constants for the keypad
// decimal to q8.8 core. No dependencies.
package kdq_pkg;

  localparam logic [7:0] KEY_ENTER = 8'h23;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;

  localparam logic [9:0]  INT_MAX_VALUE   = 10'd1023;
  localparam logic [1:0]  FRAC_DIGITS_MAX = 2'd2;
  localparam int          FRAC_BITS       = 8;
  localparam logic [14:0] CLAMP_RESET     = 15'd512;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [9:0] integer_part;
    logic [6:0] fraction_part;
    logic [1:0] fraction_digits;
    logic       minus_seen;
    logic       point_seen;
    logic       digit_seen;
  } entry_t;

endpackage

>>> rtl/core/kdq_entry.sv
// Entry state accumulator: decodes one key word and updates sign, point,
// integer and fraction state. Depends on kdq_pkg.
module kdq_entry (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd,
  input  logic [7:0]     key_code,
  output kdq_pkg::entry_t ent_o
);
  import kdq_pkg::*;

  entry_t      ent_r;
  entry_t      ent_nxt;
  logic [3:0]  digit;
  logic [13:0] int_acc;
  logic [6:0]  frac_acc;

  assign digit    = 4'(key_code - KEY_ZERO);
  assign int_acc  = 14'(ent_r.integer_part) * 14'd10 + 14'(digit);
  assign frac_acc = 7'(ent_r.fraction_part * 7'd10 + 7'(digit));

  always_comb begin
    ent_nxt = ent_r;
    if (key_code == KEY_STAR) begin
      if (!ent_r.digit_seen && !ent_r.minus_seen) begin
        ent_nxt.minus_seen = 1'b1;
      end else if (ent_r.digit_seen && !ent_r.point_seen) begin
        ent_nxt.point_seen = 1'b1;
      end
    end else if (key_code inside {[KEY_ZERO:KEY_NINE]}) begin
      ent_nxt.digit_seen = 1'b1;
      if (ent_r.point_seen) begin
        if (ent_r.fraction_digits < FRAC_DIGITS_MAX) begin
          ent_nxt.fraction_part   = frac_acc;
          ent_nxt.fraction_digits = ent_r.fraction_digits + 2'd1;
        end
      end else if (int_acc > 14'(INT_MAX_VALUE)) begin
        ent_nxt.integer_part = INT_MAX_VALUE;
      end else begin
        ent_nxt.integer_part = int_acc[9:0];
      end
    end else if (key_code == KEY_ENTER) begin
      ent_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (upd) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

>>> rtl/core/kdq_scale.sv
// Converts the entry state to clamped signed q8.8 with a clamp flag.
// Depends on kdq_pkg.
module kdq_scale (
  input  kdq_pkg::entry_t ent_i,
  input  logic [14:0]     clamp_limit,
  output logic [15:0]     value_q88,
  output logic            clamped
);
  import kdq_pkg::*;

  logic [6:0]  frac_hund;
  logic [14:0] frac_shl;
  logic [27:0] frac_prod;
  logic [7:0]  frac_q;
  logic [17:0] mag;
  logic [14:0] mag_lim;

  // one digit: f/10 = 10f/100
  assign frac_hund = (ent_i.fraction_digits == 2'd1) ?
                     7'(ent_i.fraction_part * 7'd10) : ent_i.fraction_part;
  assign frac_shl  = {frac_hund, 8'b0};
  assign frac_prod = 28'(frac_shl) * 28'(RECIP_100);
  assign frac_q    = 8'(frac_prod >> RECIP_SHIFT);
  assign mag       = {ent_i.integer_part, 8'b0} + 18'(frac_q);
  assign clamped   = mag > 18'(clamp_limit);
  assign mag_lim   = clamped ? clamp_limit : mag[14:0];
  assign value_q88 = ent_i.minus_seen ? 16'(16'd0 - 16'(mag_lim)) : 16'(mag_lim);

endmodule

>>> rtl/core/keyed_decimal_to_q8_8_core.sv
// Keypad decimal entry to q8.8: top level with key register, entry state,
// scaling and result register. Depends on kdq_pkg, kdq_entry, kdq_scale.
// A key word enters the key register, and an enter key's result goes from
// there into the result register, unless a held result word stalls it.
// Throughput: one key word per cycle; only an enter key waiting on a held result word stalls input.
// Reset (rst_n low, synchronous): pipeline empty, entry state cleared,
// clamp_limit back to 512 (2.0).
module keyed_decimal_to_q8_8_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_value_q88,
  output logic        out_clamped
);
  import kdq_pkg::*;

  logic [14:0] clamp_limit_r;
  logic        key_valid_r;
  logic [7:0]  key_r;
  logic        out_valid_r;
  logic [15:0] value_r;
  logic        clamped_r;

  logic        key_enter;
  logic        key_done;
  logic        res_load;
  logic        key_load;
  entry_t      ent;
  logic [15:0] value_nxt;
  logic        clamped_nxt;

  assign key_enter = key_r == KEY_ENTER;
  assign key_done  = key_valid_r && (!key_enter || !out_valid_r || !out_stall);
  assign res_load  = key_done && key_enter;
  assign in_stall  = key_valid_r && !key_done;
  assign key_load  = in_valid && !in_stall;

  kdq_entry u_entry (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (key_done),
    .key_code (key_r),
    .ent_o    (ent)
  );

  kdq_scale u_scale (
    .ent_i       (ent),
    .clamp_limit (clamp_limit_r),
    .value_q88   (value_nxt),
    .clamped     (clamped_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_limit_r <= CLAMP_RESET;
      key_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clamp_limit_r <= cfg_wr_data;
      end
      if (key_load) begin
        key_valid_r <= 1'b1;
      end else if (key_done) begin
        key_valid_r <= 1'b0;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_load) begin
      key_r <= in_key_code;
    end
    if (res_load) begin
      value_r   <= value_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_q88 = value_r;
  assign out_clamped   = clamped_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !key_valid_r)
    else $error("pipeline not empty after reset");

  a_stall_only_on_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> key_valid_r && key_enter && out_valid_r && out_stall)
    else $error("input stalled without a held result");

  a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> ent.integer_part == 10'd0 && ent.fraction_digits == 2'd0 &&
                 !ent.minus_seen && !ent.point_seen && !ent.digit_seen)
    else $error("entry state not cleared after enter");

  a_frac_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ent.fraction_digits == 2'd0 |-> ent.fraction_part == 7'd0)
    else $error("fraction value without fraction digits");

endmodule
